// ===== rtl/random_route_triangle_sequencer_defines.svh =====
// Assertion macros for the random-route triangle sequencer.
// Used by rtl/random_route_triangle_sequencer.sv; expects clk and rst in scope.
`ifndef RANDOM_ROUTE_TRIANGLE_SEQUENCER_DEFINES_SVH
`define RANDOM_ROUTE_TRIANGLE_SEQUENCER_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define RRTS_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("rrts: invariant violated");
`define RRTS_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rrts: implication violated");
`define RRTS_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rrts: next-cycle check violated");
`else
`define RRTS_ASSERT(label, prop)
`define RRTS_ASSERT_IMP(label, ante, cons)
`define RRTS_ASSERT_NXT(label, ante, cons)
`endif

`endif

// ===== rtl/rrts_pkg.sv =====
// Shared types and constants for the random-route triangle sequencer.
// No dependencies.
package rrts_pkg;

  localparam int NUM_NODES_DEF = 36;
  localparam int NUM_ROWS_DEF  = 8;
  localparam int VALUE_BITS    = 16;

  typedef logic [VALUE_BITS-1:0] value_t;

  localparam value_t HALF_SCALE = value_t'(1) << (VALUE_BITS - 1);

  localparam logic [3:0] STEP_COUNT_RESET = 4'd8;

  typedef enum logic [1:0] {
    REQ_EVENT    = 2'd0,
    REQ_CV_WR    = 2'd1,
    REQ_ROUTE_WR = 2'd2,
    REQ_NONE     = 2'd3
  } req_t;

endpackage

// ===== rtl/random_route_triangle_sequencer.sv =====
// Random-route triangle step sequencer, top level.
// Depends on rtl/rrts_pkg.sv and rtl/random_route_triangle_sequencer_defines.svh.
//
// Usage:
//  - Input channel (in_valid/in_ready) carries one item per handshake: an event
//    sample (reset, run toggle, clock, step button plus a random fraction) or a
//    write of one CV table or route table entry, selected by req_type.
//  - Output channel (out_valid/out_ready) returns exactly one result item per
//    input item: node, its CV, step and run state, and whether it advanced.
//  - Config channel (cfg_valid/cfg_ready) writes step_count; always ready.
//  - Path: the CV table read registers into the read stage on the accepting edge;
//    the output register loads from the read stage, and out_valid rises with it.
//  - Throughput: one item per cycle unless the receiver stalls. The route table
//    read for the next node is issued in the cycle before, so the node update loop never waits on it.
//  - Reset: step 0, node 0, running, step_count 8. Both tables read as half
//    scale until an entry is written (per-entry valid flops, no clearing pass).
//  - Receiver stall: the output register holds; a second result waits in the
//    read stage; input ready drops only when both are full and out_ready is low.
`include "random_route_triangle_sequencer_defines.svh"

module random_route_triangle_sequencer #(
  parameter int NUM_NODES = rrts_pkg::NUM_NODES_DEF,
  parameter int NUM_ROWS  = rrts_pkg::NUM_ROWS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  // config write
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [3:0]        cfg_data,
  // input items
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        req_type,
  input  logic              reset_event,
  input  logic              run_toggle,
  input  logic              clock_event,
  input  logic              button_event,
  input  rrts_pkg::value_t  random_fraction,
  input  logic [5:0]        write_index,
  input  rrts_pkg::value_t  write_value,
  // result items
  output logic              out_valid,
  input  logic              out_ready,
  output logic [5:0]        node_index,
  output rrts_pkg::value_t  cv_value,
  output logic [2:0]        step_index,
  output logic              running,
  output logic              advanced
);
  import rrts_pkg::*;

  localparam int ROUTE_DEPTH = NUM_NODES - NUM_ROWS;
  localparam int REACH       = NUM_ROWS * (NUM_ROWS + 1) / 2;
  localparam int NODE_SPAN   = (NUM_NODES > REACH) ? NUM_NODES : REACH;
  localparam int NODE_W      = $clog2(NODE_SPAN);
  localparam int CA_W        = $clog2(NUM_NODES);
  localparam int RA_W        = (ROUTE_DEPTH > 1) ? $clog2(ROUTE_DEPTH) : 1;
  localparam int SC_W        = $clog2(NUM_ROWS + 2);   // holds up to NUM_ROWS+1

  // ---------------- architectural state ----------------
  logic [3:0]        step_count;
  logic [SC_W-1:0]   step_r;
  logic [NODE_W-1:0] node_r;
  logic              run_r;
  value_t            route0_r;   // shadow of route entry 0, used after a reset event

  // ---------------- tables ----------------
  value_t            cv_mem    [NUM_NODES];
  value_t            route_mem [ROUTE_DEPTH];
  logic [NUM_NODES-1:0]   cv_written;
  logic [ROUTE_DEPTH-1:0] route_written;

  // ---------------- handshake ----------------
  logic in_acc;
  logic s1_valid;
  logic s1_move;

  assign cfg_ready = 1'b1;
  assign s1_move   = s1_valid && (!out_valid || out_ready);
  assign in_ready  = !s1_valid || s1_move;
  assign in_acc    = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_count <= STEP_COUNT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      step_count <= cfg_data;
    end
  end

  // ---------------- step / node update ----------------
  logic [SC_W-1:0]   cnt_eff;
  logic [SC_W-1:0]   sc_pre;
  logic [SC_W-1:0]   sc_inc;
  logic [SC_W-1:0]   step_next;
  logic [NODE_W-1:0] node_next;
  logic [NODE_W-1:0] node_base;
  logic              run_next;
  logic              adv_clk;
  logic              adv_btn;
  logic              moved;
  logic              zero_pre;
  logic              wrap;
  logic              is_event;
  value_t            route_cur;
  value_t            route_sel;

  assign is_event = (req_type == REQ_EVENT);

  always_comb begin
    if (step_count == '0) begin
      cnt_eff = SC_W'(1);
    end else if (32'(step_count) > NUM_ROWS) begin
      cnt_eff = SC_W'(NUM_ROWS);
    end else begin
      cnt_eff = SC_W'(step_count);
    end
  end

  always_comb begin
    sc_pre    = step_r;
    zero_pre  = 1'b0;
    run_next  = run_r;
    adv_clk   = 1'b0;
    adv_btn   = 1'b0;
    if (in_acc && is_event) begin
      if (reset_event) begin
        sc_pre   = '0;
        zero_pre = 1'b1;
      end
      if (run_toggle) begin
        run_next = !run_r;
      end
      adv_clk = run_next && clock_event;
      adv_btn = button_event;
    end
    moved     = adv_clk || adv_btn;
    sc_inc    = sc_pre + SC_W'(adv_clk) + SC_W'(adv_btn);
    wrap      = in_acc && (sc_inc >= cnt_eff);
    node_base = zero_pre ? '0 : node_r;
    route_sel = zero_pre ? route0_r : route_cur;

    if (!in_acc) begin
      step_next = step_r;
      node_next = node_r;
    end else if (wrap) begin
      step_next = '0;
      node_next = '0;
    end else begin
      step_next = sc_inc;
      if (!moved) begin
        node_next = node_base;
      end else if (sc_inc == '0) begin
        node_next = '0;
      end else begin
        // route below the random draw: move by step, else by step + 1
        node_next = node_base + NODE_W'(sc_inc)
                  + ((route_sel < random_fraction) ? NODE_W'(0) : NODE_W'(1));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step_r <= '0;
      node_r <= '0;
      run_r  <= 1'b1;
    end else begin
      step_r <= step_next;
      node_r <= node_next;
      run_r  <= run_next;
    end
  end

  // route table: read the next node's entry in the cycle before it is used
  logic              route_we;
  logic [RA_W-1:0]   route_waddr;
  logic [RA_W-1:0]   route_raddr;
  logic              route_rin;
  value_t            route_q;
  logic              route_fwd;
  value_t            route_fwd_d;
  logic              route_vld;
  logic              route_inr;

  assign route_we    = in_acc && (req_type == REQ_ROUTE_WR)
                    && (32'(write_index) < ROUTE_DEPTH);
  assign route_waddr = RA_W'(write_index);
  assign route_raddr = RA_W'(node_next);
  assign route_rin   = 32'(node_next) < ROUTE_DEPTH;

  always_ff @(posedge clk) begin
    if (route_we) begin
      route_mem[route_waddr] <= write_value;
    end
    route_q     <= route_mem[route_raddr];
    route_fwd_d <= write_value;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      route_written <= '0;
      route_fwd     <= 1'b0;
      route_vld     <= 1'b0;
      route_inr     <= 1'b1;
      route0_r      <= HALF_SCALE;
    end else begin
      if (route_we) begin
        route_written[route_waddr] <= 1'b1;
        if (route_waddr == '0) begin
          route0_r <= write_value;
        end
      end
      // same-entry write in this cycle: forward its data
      route_fwd <= route_we && (route_waddr == route_raddr);
      route_vld <= route_written[route_raddr];
      route_inr <= route_rin;
    end
  end

  always_comb begin
    if (!route_inr) begin
      route_cur = '0;
    end else if (route_fwd) begin
      route_cur = route_fwd_d;
    end else if (route_vld) begin
      route_cur = route_q;
    end else begin
      route_cur = HALF_SCALE;
    end
  end

  // ---------------- CV table: read final node, result stage ----------------
  logic              cv_we;
  logic [CA_W-1:0]   cv_waddr;
  logic [CA_W-1:0]   cv_raddr;
  value_t            cv_q;
  value_t            cv_fwd_d;
  logic              cv_fwd;
  logic              cv_vld;
  logic              cv_inr;
  value_t            cv_cur;

  logic [NODE_W-1:0] s1_node;
  logic [SC_W-1:0]   s1_step;
  logic              s1_run;
  logic              s1_adv;

  assign cv_we    = in_acc && (req_type == REQ_CV_WR) && (32'(write_index) < NUM_NODES);
  assign cv_waddr = CA_W'(write_index);
  assign cv_raddr = CA_W'(node_next);

  always_ff @(posedge clk) begin
    if (cv_we) begin
      cv_mem[cv_waddr] <= write_value;
    end
    if (in_acc) begin
      cv_q     <= cv_mem[cv_raddr];
      cv_fwd_d <= write_value;
      cv_fwd   <= cv_we && (cv_waddr == cv_raddr);
      cv_vld   <= cv_written[cv_raddr];
      cv_inr   <= 32'(node_next) < NUM_NODES;
      s1_node  <= node_next;
      s1_step  <= step_next;
      s1_run   <= run_next;
      s1_adv   <= moved;
    end
  end

  always_comb begin
    if (!cv_inr) begin
      cv_cur = '0;
    end else if (cv_fwd) begin
      cv_cur = cv_fwd_d;
    end else if (cv_vld) begin
      cv_cur = cv_q;
    end else begin
      cv_cur = HALF_SCALE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cv_written <= '0;
      s1_valid   <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cv_we) begin
        cv_written[cv_waddr] <= 1'b1;
      end
      s1_valid  <= in_acc || (s1_valid && !s1_move);
      out_valid <= s1_move || (out_valid && !out_ready);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (s1_move) begin
      node_index <= 6'(s1_node);
      cv_value   <= cv_cur;
      step_index <= 3'(s1_step);
      running    <= s1_run;
      advanced   <= s1_adv;
    end
  end

  // ---------------- assertions ----------------
  `RRTS_ASSERT(a_step_below_rows, step_r < SC_W'(NUM_ROWS))
  `RRTS_ASSERT_IMP(a_step_zero_node_zero, step_r == '0, node_r == '0)
  `RRTS_ASSERT_NXT(a_s1_holds, s1_valid && !s1_move, s1_valid && $stable(s1_node))
  `RRTS_ASSERT_NXT(a_button_advances, in_acc && is_event && button_event, s1_adv)

endmodule
